[hdl/lpg_pkg.sv]
// Package for the LED pattern generator: mode and register codes, pattern
// marks and the counter state record shared by the step logic and the top level.
// No dependencies.
package lpg_pkg;

  localparam logic [2:0] MODE_BREATHE = 3'd0;
  localparam logic [2:0] MODE_SLOW    = 3'd1;
  localparam logic [2:0] MODE_FAST    = 3'd2;
  localparam logic [2:0] MODE_PULSE   = 3'd3;
  localparam logic [2:0] MODE_IDLE    = 3'd4;

  localparam logic [1:0] REG_LIGHT_MODE  = 2'd0;
  localparam logic [1:0] REG_ACTIVE_HIGH = 2'd1;
  localparam logic [1:0] REG_PWM_PERIOD  = 2'd2;

  localparam logic [15:0] TICK_MAX       = 16'hFFFF;
  localparam logic [15:0] RISE_END       = 16'd1600;
  localparam logic [15:0] FALL_START     = 16'd2000;
  localparam logic [15:0] MARK_SLOW      = 16'd1000;
  localparam logic [15:0] MARK_FAST      = 16'd300;
  localparam logic [15:0] MARK_PULSE     = 16'd100;
  localparam logic [15:0] PULSE_HOLD_END = 16'd1000;

  localparam logic [6:0] STEP_LAST = 7'd79;
  localparam logic [6:0] P100_LAST = 7'd99;
  localparam logic [8:0] P300_LAST = 9'd299;
  localparam logic [9:0] P1K_LAST  = 10'd999;

  localparam logic [4:0] THR_PEAK = 5'd20;

  // phase fields track tick modulo 80, 100, 300 and 1000
  typedef struct packed {
    logic [15:0] tick;
    logic [6:0]  ph80;
    logic [6:0]  ph100;
    logic [8:0]  ph300;
    logic [9:0]  ph1000;
    logic [15:0] pwm;
    logic [4:0]  thr;
    logic        led;
  } state_t;

endpackage

[hdl/lpg_step.sv]
// Next-state logic for one tick of the LED pattern generator.
// Depends on lpg_pkg.
module lpg_step (
  input  logic [2:0]     light_mode,
  input  logic [15:0]    pwm_period,
  input  lpg_pkg::state_t cur,
  output lpg_pkg::state_t nxt
);
  import lpg_pkg::*;

  state_t      adv;
  logic [15:0] pwm_inc;
  logic [4:0]  thr_new;
  logic        restart;
  logic        advance;

  always_comb begin
    adv = cur;
    if (cur.tick == TICK_MAX) begin
      adv.tick   = '0;
      adv.ph80   = '0;
      adv.ph100  = '0;
      adv.ph300  = '0;
      adv.ph1000 = '0;
    end else begin
      adv.tick   = cur.tick + 16'd1;
      adv.ph80   = (cur.ph80 == STEP_LAST) ? '0 : cur.ph80 + 7'd1;
      adv.ph100  = (cur.ph100 == P100_LAST) ? '0 : cur.ph100 + 7'd1;
      adv.ph300  = (cur.ph300 == P300_LAST) ? '0 : cur.ph300 + 9'd1;
      adv.ph1000 = (cur.ph1000 == P1K_LAST) ? '0 : cur.ph1000 + 10'd1;
    end
  end

  always_comb begin
    nxt     = cur;
    restart = 1'b0;
    advance = 1'b1;
    pwm_inc = cur.pwm + 16'd1;
    thr_new = cur.thr;
    unique case (light_mode)
      MODE_BREATHE: begin
        nxt.led = (cur.pwm > {11'd0, cur.thr});
        nxt.pwm = (pwm_inc >= pwm_period) ? '0 : pwm_inc;
        if (cur.ph80 == '0) begin
          if (cur.tick < RISE_END) begin
            thr_new = cur.thr + 5'd1;
          end else if (cur.tick >= FALL_START) begin
            thr_new = cur.thr - 5'd1;
          end
          restart = (thr_new == '0);
        end
        nxt.thr = thr_new;
      end
      MODE_SLOW: begin
        if (cur.ph1000 == '0) begin
          if (cur.tick == '0) nxt.led = 1'b1;
          else if (cur.tick == MARK_SLOW) nxt.led = 1'b0;
          else restart = 1'b1;
        end
      end
      MODE_FAST: begin
        if (cur.ph300 == '0) begin
          if (cur.tick == '0) nxt.led = 1'b1;
          else if (cur.tick == MARK_FAST) nxt.led = 1'b0;
          else restart = 1'b1;
        end
      end
      MODE_PULSE: begin
        if (cur.ph100 == '0) begin
          if (cur.tick == '0) nxt.led = 1'b1;
          else if (cur.tick == MARK_PULSE) nxt.led = 1'b0;
          else if (cur.tick >= PULSE_HOLD_END) restart = 1'b1;
        end
      end
      default: begin
        advance = 1'b0;
      end
    endcase
    if (restart) begin
      nxt.tick   = '0;
      nxt.ph80   = '0;
      nxt.ph100  = '0;
      nxt.ph300  = '0;
      nxt.ph1000 = '0;
    end else if (advance) begin
      nxt.tick   = adv.tick;
      nxt.ph80   = adv.ph80;
      nxt.ph100  = adv.ph100;
      nxt.ph300  = adv.ph300;
      nxt.ph1000 = adv.ph1000;
    end
  end

endmodule

[hdl/led_pattern_generator_top.sv]
// LED pattern generator top level: counter state, configuration registers
// and the result register. Depends on lpg_pkg and lpg_step.
//
// Usage: every item on the in_ channel is one tick (in_tdata[0] = 1 advances
// the pattern, 0 leaves it and reports the current levels). Each accepted
// item yields exactly one result on the out_ channel carrying the LED state
// after the tick and the pin level after polarity.
// The result is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle unless out_tready stalls; the counter update
// is a single pass of compares and increments between the state and result registers.
// in_tready stays high while the result register is empty or being drained,
// so a stall on out_tready holds the result and back-pressures the input.
// Configuration: cfg_wr_en with cfg_index 0 (light_mode), 1 (active_high)
// or 2 (pwm_period); writing light_mode clears the tick, PWM and threshold
// counters. Write only while no item is in flight.
// Reset (rst_n low, synchronous): idle mode, active-high pin, PWM period 10,
// all counters cleared, LED unlit, result register empty.
module led_pattern_generator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] tick
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] led_lit, [1] pin_level
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import lpg_pkg::*;

  logic [2:0]  mode_r;
  logic        active_high_r;
  logic [15:0] period_r;
  state_t      state_r;
  state_t      state_nxt;
  state_t      step_nxt;
  logic        out_valid_r;
  logic        led_out_r;
  logic        pin_out_r;
  logic        in_acc;
  logic        led_nxt;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, pin_out_r, led_out_r};

  lpg_step u_step (
    .light_mode (mode_r),
    .pwm_period (period_r),
    .cur        (state_r),
    .nxt        (step_nxt)
  );

  always_comb begin
    state_nxt = state_r;
    if (cfg_wr_en && cfg_index == REG_LIGHT_MODE) begin
      state_nxt.tick   = '0;
      state_nxt.ph80   = '0;
      state_nxt.ph100  = '0;
      state_nxt.ph300  = '0;
      state_nxt.ph1000 = '0;
      state_nxt.pwm    = '0;
      state_nxt.thr    = '0;
    end else if (in_acc && in_tdata[0]) begin
      state_nxt = step_nxt;
    end
  end

  assign led_nxt = state_nxt.led;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      active_high_r <= 1'b1;
      period_r      <= 16'd10;
      state_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_LIGHT_MODE:  mode_r <= cfg_wdata[2:0];
          REG_ACTIVE_HIGH: active_high_r <= cfg_wdata[0];
          REG_PWM_PERIOD:  period_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      led_out_r <= led_nxt;
      pin_out_r <= active_high_r ? led_nxt : !led_nxt;
    end
  end

`ifndef SYNTHESIS
  a_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.tick == '0 |-> (state_r.ph80 == '0 && state_r.ph100 == '0 &&
                            state_r.ph300 == '0 && state_r.ph1000 == '0))
    else $error("phase counters out of step with tick counter");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("accepted item produced no result");

  a_thr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.thr <= THR_PEAK)
    else $error("brightness threshold beyond its peak");

  a_mode_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en && cfg_index == REG_LIGHT_MODE |=>
      (state_r.tick == '0 && state_r.pwm == '0 && state_r.thr == '0))
    else $error("mode write did not clear counters");
`endif

endmodule
